### hdl/arbt_pkg.sv
// arbt_pkg: types and constants shared by the address range ban table.
// No dependencies.
`timescale 1ns / 1ps
package arbt_pkg;
	localparam int MaxRanges = 64;

	localparam logic [1:0] FUNC_ADD    = 2'd0;
	localparam logic [1:0] FUNC_REMOVE = 2'd1;
	localparam logic [1:0] FUNC_CHECK  = 2'd2;
	localparam logic [1:0] FUNC_NEXT   = 2'd3;

	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_NOMATCH = 2'd2;

	// cell load select
	localparam logic [1:0] SEL_HOLD  = 2'd0;
	localparam logic [1:0] SEL_LEFT  = 2'd1;
	localparam logic [1:0] SEL_RIGHT = 2'd2;
	localparam logic [1:0] SEL_REP   = 2'd3;

	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] low_addr;
		logic [31:0] high_addr;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [6:0]  count;
		logic        found;
		logic [31:0] range_low;
		logic [31:0] range_high;
	} rsp_t;

	// what a cell reports about its range against the current item
	typedef struct packed {
		logic        valid;
		logic        below;   // hi < bound used for first_not_below
		logic        le_hi;   // lo <= bound used for first_above
		logic        le_q;    // lo <= query (next)
		logic [31:0] lo;
		logic [31:0] hi;
	} cell_info_t;

	// broadcast command to every cell
	typedef struct packed {
		logic        cmp_en;   // latch comparison flags
		logic [31:0] nb_bound; // bound for "hi below"
		logic [31:0] fa_bound; // bound for "lo at or below"
		logic [31:0] q_bound;
		logic        shift;    // apply the splice
	} cell_cmd_t;
endpackage

### hdl/arbt_cell.sv
// arbt_cell: one slot of the sorted range chain.
// Depends on arbt_pkg. Loads from its left or right neighbour, or from rep, on a splice.
`timescale 1ns / 1ps
module arbt_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  arbt_pkg::cell_cmd_t   cmd,
	input  logic [1:0]            sel,      // arbt_pkg::SEL_* load select
	input  logic                  new_valid,
	input  logic [63:0]           rep,
	input  logic                  left_valid,
	input  logic [63:0]           left_data,
	input  logic                  right_valid,
	input  logic [63:0]           right_data,
	output arbt_pkg::cell_info_t  info
);
	logic        valid_q;
	logic [63:0] data_q;
	logic        below_q, le_hi_q, le_q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.shift) begin
			case (sel)
				arbt_pkg::SEL_LEFT:  valid_q <= left_valid;
				arbt_pkg::SEL_RIGHT: valid_q <= right_valid;
				arbt_pkg::SEL_REP:   valid_q <= new_valid;
				default: valid_q <= valid_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.shift) begin
			case (sel)
				arbt_pkg::SEL_LEFT:  data_q <= left_data;
				arbt_pkg::SEL_RIGHT: data_q <= right_data;
				arbt_pkg::SEL_REP:   data_q <= rep;
				default: data_q <= data_q;
			endcase
		end
		if (cmd.cmp_en) begin
			below_q <= data_q[31:0] < cmd.nb_bound;
			le_hi_q <= data_q[63:32] <= cmd.fa_bound;
			le_q_q  <= data_q[63:32] <= cmd.q_bound;
		end
	end

	assign info = '{valid: valid_q, below: below_q, le_hi: le_hi_q, le_q: le_q_q,
		lo: data_q[63:32], hi: data_q[31:0]};
endmodule

### hdl/address_range_ban_table.sv
// address_range_ban_table: top level, sequencer around a chain of range cells.
// Depends on arbt_pkg and arbt_cell.
`timescale 1ns / 1ps
// Usage
//   Command channel: drive req and pulse start while busy is low; the item is
//   taken at that edge and busy rises until the result is shown.
//   Result channel: rsp is valid for exactly one cycle while done is high;
//   the receiver cannot stall, so it must take the result in that cycle.
//   Phases: compare in every cell, count the flags (a registered popcount per
//   flag), decide and splice, show the result. A new item can be taken in the
//   cycle that done is high, but not while busy is high, so an item is not
//   taken before the last one's result is shown. A tail move of d > 1 places
//   runs one place per cycle.
//   The store is a row of MAX_RANGES cells kept sorted by lower bound and
//   packed to the left; each cell holds a valid bit. Add merges all ranges
//   that touch the span into one, remove may split one range into two, and
//   the splice moves the tail left or right by the change in entry count.
//   Reset clears every valid bit and the sequencer; no clearing pass runs.
//   Because valid entries are contiguous, the flag counts equal the indices
//   i and j that a linear scan would find.
module address_range_ban_table #(
	parameter int MAX_RANGES = arbt_pkg::MaxRanges
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  arbt_pkg::req_t   req,
	output logic             busy,
	output logic             done,
	output arbt_pkg::rsp_t   rsp
);
	localparam int CW = $clog2(MAX_RANGES + 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_CMP  = 2'd1;
	localparam logic [1:0] S_CNT  = 2'd2;
	localparam logic [1:0] S_UPD  = 2'd3;

	logic [1:0]   state_q;
	arbt_pkg::req_t req_q;
	arbt_pkg::cell_cmd_t cmd;
	arbt_pkg::cell_info_t info [MAX_RANGES];
	logic [CW-1:0] n_q, i_q, j_q, q_q;
	logic [63:0]  rep [MAX_RANGES];
	logic         nval [MAX_RANGES];
	logic [CW-1:0] cnt_v, cnt_b, cnt_h, cnt_q;

	// touch-extended bounds for add
	logic [31:0] elo, ehi;
	assign elo = (req_q.low_addr == '0) ? '0 : req_q.low_addr - 32'd1;
	assign ehi = (req_q.high_addr == '1) ? '1 : req_q.high_addr + 32'd1;

	always_comb begin
		cmd.cmp_en   = (state_q == S_CMP);
		cmd.nb_bound = (req_q.func == arbt_pkg::FUNC_ADD) ? elo : req_q.low_addr;
		cmd.fa_bound = (req_q.func == arbt_pkg::FUNC_ADD) ? ehi : req_q.high_addr;
		cmd.q_bound  = req_q.low_addr;
		cmd.shift    = 1'b0;
	end

	// flag counts (valid entries are contiguous, flags monotone)
	always_comb begin
		cnt_v = '0; cnt_b = '0; cnt_h = '0; cnt_q = '0;
		for (int k = 0; k < MAX_RANGES; k++) begin
			cnt_v = cnt_v + CW'(info[k].valid);
			cnt_b = cnt_b + CW'(info[k].valid & info[k].below);
			cnt_h = cnt_h + CW'(info[k].valid & info[k].le_hi);
			cnt_q = cnt_q + CW'(info[k].valid & info[k].le_q);
		end
	end

	// decision from indices
	logic        inv;
	logic        hit;
	logic [31:0] lo_i, hi_j1;
	logic [CW-1:0] m;
	logic        sp_lo, sp_hi;
	logic [1:0]  nrep;
	logic        full_fail;
	logic [CW-1:0] jm1;

	assign inv  = req_q.low_addr > req_q.high_addr;
	assign hit  = j_q > i_q;
	assign jm1  = j_q - CW'(1);
	always_comb begin
		lo_i  = '0;
		hi_j1 = '0;
		for (int k = 0; k < MAX_RANGES; k++) begin
			if (CW'(k) == i_q) lo_i = info[k].lo;
			if (CW'(k) == jm1) hi_j1 = info[k].hi;
		end
	end
	assign m = j_q - i_q;
	assign sp_lo = hit && lo_i < req_q.low_addr;
	assign sp_hi = hit && hi_j1 > req_q.high_addr;

	always_comb begin
		nrep = 2'd0;
		full_fail = 1'b0;
		unique case (req_q.func)
			arbt_pkg::FUNC_ADD: begin
				nrep = 2'd1;
				full_fail = !hit && (n_q >= CW'(MAX_RANGES));
			end
			arbt_pkg::FUNC_REMOVE: begin
				nrep = {1'b0, sp_lo} + {1'b0, sp_hi};
				full_fail = hit && ({1'b0, n_q} - {1'b0, m} + (CW+1)'(nrep)
					> (CW+1)'(MAX_RANGES));
			end
			default: nrep = 2'd0;
		endcase
	end

	logic do_splice;
	assign do_splice = (state_q == S_UPD) && !inv && !full_fail &&
		((req_q.func == arbt_pkg::FUNC_ADD) ||
		 (req_q.func == arbt_pkg::FUNC_REMOVE && hit));

	logic [63:0] r0, r1;
	always_comb begin
		if (req_q.func == arbt_pkg::FUNC_ADD) begin
			r0 = {(hit && lo_i < req_q.low_addr) ? lo_i : req_q.low_addr,
				(hit && hi_j1 > req_q.high_addr) ? hi_j1 : req_q.high_addr};
			r1 = r0;
		end else begin
			r0 = sp_lo ? {lo_i, req_q.low_addr - 32'd1}
				: {req_q.high_addr + 32'd1, hi_j1};
			r1 = {req_q.high_addr + 32'd1, hi_j1};
		end
	end

	// The decision is taken in the first S_UPD cycle, while every cell still
	// holds its value, and kept for the later steps. The tail moves by
	// |m - nrep| places, one per cycle; the replacement slots are loaded in
	// the last step, together with the final move.
	logic [CW-1:0] gap_q;      // places still to move after this cycle
	logic          dir_q;      // 1 move left (shrink), 0 move right (grow)
	logic          rep_done_q; // decision held in the registers below
	logic          splice_q;
	logic [1:0]    nrep_q;
	logic [63:0]   r0_q, r1_q;

	logic          first_upd;
	logic [CW-1:0] move_len;
	logic [CW-1:0] steps_e;    // moves left, this cycle included
	logic          spl_e, dir_e, last_e;
	logic [1:0]    nrep_e;
	logic [63:0]   r0_e, r1_e;

	assign first_upd = (state_q == S_UPD) && !rep_done_q;
	assign move_len  = (m > CW'(nrep)) ? m - CW'(nrep) : CW'(nrep) - m;
	assign steps_e   = first_upd ? move_len : gap_q;
	assign spl_e     = first_upd ? do_splice : splice_q;
	assign dir_e     = first_upd ? (m > CW'(nrep)) : dir_q;
	assign nrep_e    = first_upd ? nrep : nrep_q;
	assign r0_e      = first_upd ? r0 : r0_q;
	assign r1_e      = first_upd ? r1 : r1_q;
	assign last_e    = steps_e <= CW'(1);

	logic [1:0] sel_eff [MAX_RANGES];
	logic       shift_en;
	always_comb begin
		shift_en = (state_q == S_UPD) && spl_e;
		for (int k = 0; k < MAX_RANGES; k++) begin
			rep[k]  = (CW'(k) == i_q) ? r0_e : r1_e;
			nval[k] = 1'b1;
			if (!shift_en || CW'(k) < i_q) begin
				sel_eff[k] = arbt_pkg::SEL_HOLD;
			end else if ({1'b0, CW'(k)} < {1'b0, i_q} + (CW+1)'(nrep_e)) begin
				// replacement slots: loaded last, before that they move with the tail
				if (last_e) sel_eff[k] = arbt_pkg::SEL_REP;
				else sel_eff[k] = dir_e ? arbt_pkg::SEL_RIGHT : arbt_pkg::SEL_LEFT;
			end else if (steps_e == '0) begin
				sel_eff[k] = arbt_pkg::SEL_HOLD;
			end else begin
				sel_eff[k] = dir_e ? arbt_pkg::SEL_RIGHT : arbt_pkg::SEL_LEFT;
			end
		end
	end

	arbt_pkg::cell_cmd_t ccmd;
	always_comb begin
		ccmd = cmd;
		ccmd.shift = shift_en;
	end

	for (genvar g = 0; g < MAX_RANGES; g++) begin : g_cell
		logic        lv, rv;
		logic [63:0] ld, rd;
		if (g == 0) begin : g_l
			assign lv = 1'b0; assign ld = '0;
		end else begin : g_l
			assign lv = info[g-1].valid; assign ld = {info[g-1].lo, info[g-1].hi};
		end
		if (g == MAX_RANGES - 1) begin : g_r
			assign rv = 1'b0; assign rd = '0;
		end else begin : g_r
			assign rv = info[g+1].valid; assign rd = {info[g+1].lo, info[g+1].hi};
		end
		arbt_cell u_cell (
			.clk(clk), .arst_n(arst_n), .cmd(ccmd), .sel(sel_eff[g]),
			.new_valid(nval[g]), .rep(rep[g]),
			.left_valid(lv), .left_data(ld), .right_valid(rv), .right_data(rd),
			.info(info[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done    <= 1'b0;
			gap_q   <= '0;
			dir_q   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (first_upd) dir_q <= dir_e;
			unique case (state_q)
				S_IDLE: if (start) state_q <= S_CMP;
				S_CMP:  state_q <= S_CNT;
				S_CNT:  state_q <= S_UPD;
				S_UPD: begin
					if (spl_e && steps_e > CW'(1)) begin
						gap_q <= steps_e - CW'(1);
					end else begin
						state_q <= S_IDLE;
						done    <= 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// marks that the decision for this item is held
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rep_done_q <= 1'b0;
		else if (state_q != S_UPD) rep_done_q <= 1'b0;
		else rep_done_q <= 1'b1;
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) req_q <= req;
		if (state_q == S_CNT) begin
			n_q <= cnt_v;
			i_q <= cnt_b;
			j_q <= (cnt_h > cnt_b) ? cnt_h : cnt_b;
			q_q <= cnt_q;
		end
		if (first_upd) begin
			splice_q <= do_splice;
			nrep_q   <= nrep;
			r0_q     <= r0;
			r1_q     <= r1;
		end
		if (first_upd) begin
			rsp.status     <= arbt_pkg::ST_NOMATCH;
			rsp.count      <= '0;
			rsp.found      <= 1'b0;
			rsp.range_low  <= '0;
			rsp.range_high <= '0;
			if (req_q.func == arbt_pkg::FUNC_NEXT) begin
				if (!inv && q_q < n_q) begin
					rsp.status <= arbt_pkg::ST_DONE;
					rsp.found  <= 1'b1;
					rsp.range_low  <= info[q_q[$clog2(MAX_RANGES)-1:0]].lo;
					rsp.range_high <= info[q_q[$clog2(MAX_RANGES)-1:0]].hi;
				end else if (inv && n_q != '0) begin
					rsp.status <= arbt_pkg::ST_DONE;
					rsp.found  <= 1'b1;
					rsp.range_low  <= info[0].lo;
					rsp.range_high <= info[0].hi;
				end
			end else if (!inv) begin
				if (full_fail) begin
					rsp.status <= arbt_pkg::ST_FULL;
				end else if (req_q.func == arbt_pkg::FUNC_ADD) begin
					rsp.status <= arbt_pkg::ST_DONE;
					rsp.count  <= 7'(m);
				end else if (hit) begin
					rsp.status <= arbt_pkg::ST_DONE;
					rsp.count  <= 7'(m);
					rsp.found  <= req_q.func == arbt_pkg::FUNC_CHECK;
				end
			end
		end
	end

	assign busy = (state_q != S_IDLE);

`ifndef SYNTHESIS
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held");
	a_busy_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("item not taken");
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_v <= CW'(MAX_RANGES)) else $error("overfill");
`endif
endmodule

### tb/address_range_ban_table_chk.sv
// address_range_ban_table_chk: watches the command and result channels of the
// ban table, predicts each result and compares it. Depends on arbt_pkg.
`timescale 1ns / 1ps
module address_range_ban_table_chk (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           busy,
	input  arbt_pkg::req_t req,
	input  logic           done,
	input  arbt_pkg::rsp_t rsp,
	output int             fail_count,
	output int             pending,
	output int             tbl_entries
);
	logic [31:0] tbl_lo [arbt_pkg::MaxRanges];
	logic [31:0] tbl_hi [arbt_pkg::MaxRanges];
	int          tbl_n;
	arbt_pkg::rsp_t rsp_due [$];

	assign tbl_entries = tbl_n;

	// replace entries i..j-1 by n new ones held in nlo/nhi
	task automatic splice_ranges(input int i, input int j, input int n,
			input logic [31:0] nlo [2], input logic [31:0] nhi [2]);
		logic [31:0] slo [arbt_pkg::MaxRanges];
		logic [31:0] shi [arbt_pkg::MaxRanges];
		int k, m;
		m = 0;
		for (k = 0; k < i; k++) begin
			slo[m] = tbl_lo[k]; shi[m] = tbl_hi[k]; m++;
		end
		for (k = 0; k < n; k++) begin
			slo[m] = nlo[k]; shi[m] = nhi[k]; m++;
		end
		for (k = j; k < tbl_n; k++) begin
			slo[m] = tbl_lo[k]; shi[m] = tbl_hi[k]; m++;
		end
		tbl_lo = slo; tbl_hi = shi; tbl_n = m;
	endtask

	task automatic predict_ban(input arbt_pkg::req_t r, output arbt_pkg::rsp_t o);
		logic [31:0] lo, hi, elo, ehi;
		logic [31:0] nlo [2];
		logic [31:0] nhi [2];
		int i, j, n;
		lo = r.low_addr; hi = r.high_addr;
		o = '0; o.status = arbt_pkg::ST_NOMATCH;
		if (r.func == arbt_pkg::FUNC_NEXT) begin
			i = 0;
			if (lo <= hi) while (i < tbl_n && tbl_lo[i] <= lo) i++;
			if (i < tbl_n) begin
				o.status = arbt_pkg::ST_DONE; o.found = 1'b1;
				o.range_low = tbl_lo[i]; o.range_high = tbl_hi[i];
			end
		end else if (lo <= hi) begin
			// touch test saturates instead of wrapping
			elo = (r.func == arbt_pkg::FUNC_ADD && lo != 0) ? lo - 1 : lo;
			ehi = (r.func == arbt_pkg::FUNC_ADD && hi != '1) ? hi + 1 : hi;
			i = 0;
			while (i < tbl_n && tbl_hi[i] < elo) i++;
			j = i;
			while (j < tbl_n && tbl_lo[j] <= ehi) j++;
			case (r.func)
				arbt_pkg::FUNC_ADD: begin
					o.count = 7'(j - i);
					if (j == i && tbl_n >= arbt_pkg::MaxRanges) o.status = arbt_pkg::ST_FULL;
					else begin
						if (j > i) begin
							if (tbl_lo[i] < lo) lo = tbl_lo[i];
							if (tbl_hi[j-1] > hi) hi = tbl_hi[j-1];
						end
						nlo[0] = lo; nhi[0] = hi;
						splice_ranges(i, j, 1, nlo, nhi);
						o.status = arbt_pkg::ST_DONE;
					end
				end
				arbt_pkg::FUNC_REMOVE: begin
					if (j > i) begin
						n = 0;
						if (tbl_lo[i] < lo) begin
							nlo[n] = tbl_lo[i]; nhi[n] = lo - 1; n++;
						end
						if (tbl_hi[j-1] > hi) begin
							nlo[n] = hi + 1; nhi[n] = tbl_hi[j-1]; n++;
						end
						if (tbl_n - (j - i) + n > arbt_pkg::MaxRanges)
							o.status = arbt_pkg::ST_FULL;
						else begin
							o.count = 7'(j - i);
							splice_ranges(i, j, n, nlo, nhi);
							o.status = arbt_pkg::ST_DONE;
						end
					end
				end
				default: begin
					o.count = 7'(j - i);
					if (j > i) begin
						o.status = arbt_pkg::ST_DONE; o.found = 1'b1;
					end
				end
			endcase
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		arbt_pkg::rsp_t e;
		if (!arst_n) begin
			tbl_n = 0; fail_count = 0; rsp_due.delete(); pending = 0;
		end else begin
			// result first: a new item may be taken in the done cycle
			if (done) begin
				if (rsp_due.size() == 0) begin
					$error("result with no item outstanding");
					fail_count++;
				end else begin
					e = rsp_due.pop_front();
					if (rsp.status !== e.status) begin
						$error("status exp %0d got %0d", e.status, rsp.status); fail_count++;
					end
					if (rsp.count !== e.count) begin
						$error("count exp %0d got %0d", e.count, rsp.count); fail_count++;
					end
					if (rsp.found !== e.found) begin
						$error("found exp %0d got %0d", e.found, rsp.found); fail_count++;
					end
					if (rsp.range_low !== e.range_low) begin
						$error("range_low exp %h got %h", e.range_low, rsp.range_low);
						fail_count++;
					end
					if (rsp.range_high !== e.range_high) begin
						$error("range_high exp %h got %h", e.range_high, rsp.range_high);
						fail_count++;
					end
				end
			end
			if (start && !busy) begin
				predict_ban(req, e);
				rsp_due.push_back(e);
			end
			pending = rsp_due.size();
		end
	end
endmodule

### tb/address_range_ban_table_tb.sv
// address_range_ban_table_tb: stimulus and verdict for the ban table.
// Depends on arbt_pkg, address_range_ban_table and address_range_ban_table_chk.
`timescale 1ns / 1ps
module address_range_ban_table_tb;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	arbt_pkg::req_t req = '0;
	logic busy, done;
	arbt_pkg::rsp_t rsp;
	int   fail_count, pending, tbl_entries;
	int   n_items = 0;
	logic [31:0] anchor;

	always #5 clk = ~clk;

	address_range_ban_table uut (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req),
		.busy(busy), .done(done), .rsp(rsp)
	);

	address_range_ban_table_chk chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .fail_count(fail_count), .pending(pending),
		.tbl_entries(tbl_entries)
	);

	// one item: random gap, then hold start until the block takes it
	task automatic send_item(input logic [1:0] f, input logic [31:0] lo,
			input logic [31:0] hi);
		int gap;
		gap = $urandom_range(0, 6);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req   <= '{func: f, low_addr: lo, high_addr: hi};
		start <= 1'b1;
		do @(posedge clk); while (busy);
		@(negedge clk);
		n_items++;
	endtask

	// addresses clustered near an anchor so ranges meet and overlap often
	function automatic logic [31:0] near_addr();
		case ($urandom_range(0, 9))
			0:       return $urandom();
			1:       return $urandom_range(0, 40);
			2:       return 32'hFFFF_FFFF - $urandom_range(0, 40);
			default: return anchor + $urandom_range(0, 2000);
		endcase
	endfunction

	initial begin
		logic [31:0] a, b, w;
		logic [1:0]  f;
		int k;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: extremes, every operation, the special cases
		send_item(arbt_pkg::FUNC_NEXT,   32'd5, 32'd0);          // empty table
		send_item(arbt_pkg::FUNC_CHECK,  32'd0, 32'd0);
		send_item(arbt_pkg::FUNC_ADD,    32'd0, 32'd10);         // range at zero
		send_item(arbt_pkg::FUNC_CHECK,  32'd0, 32'd0);
		send_item(arbt_pkg::FUNC_ADD,    32'd11, 32'd20);        // touching merge
		send_item(arbt_pkg::FUNC_ADD,    32'hFFFF_FFF0, 32'hFFFF_FFFF);
		send_item(arbt_pkg::FUNC_ADD,    32'd100, 32'd50);       // inverted
		send_item(arbt_pkg::FUNC_REMOVE, 32'd9, 32'd5);
		send_item(arbt_pkg::FUNC_CHECK,  32'd9, 32'd5);
		send_item(arbt_pkg::FUNC_ADD,    32'd40, 32'd60);
		send_item(arbt_pkg::FUNC_ADD,    32'd80, 32'd90);
		send_item(arbt_pkg::FUNC_CHECK,  32'd0, 32'hFFFF_FFFF);
		send_item(arbt_pkg::FUNC_REMOVE, 32'd5, 32'd6);          // split
		send_item(arbt_pkg::FUNC_REMOVE, 32'd1000, 32'd2000);    // no overlap
		send_item(arbt_pkg::FUNC_NEXT,   32'd0, 32'hFFFF_FFFF);
		send_item(arbt_pkg::FUNC_NEXT,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(arbt_pkg::FUNC_NEXT,   32'd1, 32'd0);          // lowest range
		send_item(arbt_pkg::FUNC_ADD,    32'd0, 32'hFFFF_FFFF);  // swallow all
		send_item(arbt_pkg::FUNC_REMOVE, 32'd0, 32'hFFFF_FFFF);
		// fill the table, then hit full on add and on split
		for (k = 0; k < arbt_pkg::MaxRanges; k++)
			send_item(arbt_pkg::FUNC_ADD, 32'(k * 4), 32'(k * 4 + 2));
		send_item(arbt_pkg::FUNC_ADD, 32'h8000_0000, 32'h8000_0001);
		send_item(arbt_pkg::FUNC_REMOVE, 32'd5, 32'd5);
		send_item(arbt_pkg::FUNC_REMOVE, 32'd0, 32'hFFFF_FFFF);

		// hold off until every result is in
		start <= 1'b0;
		wait (pending == 0);
		@(negedge clk);

		anchor = $urandom();
		for (k = 0; k < 1064; k++) begin
			if (k % 200 == 0) anchor = $urandom();
			f = 2'($urandom_range(0, 3));
			// lean to add when sparse, to remove when near full
			if ($urandom_range(0, 3) == 0)
				f = (tbl_entries > arbt_pkg::MaxRanges - 8) ? arbt_pkg::FUNC_REMOVE
					: arbt_pkg::FUNC_ADD;
			a = near_addr();
			w = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 60);
			b = a + w;
			if (b < a) b = 32'hFFFF_FFFF;
			if ($urandom_range(0, 15) == 0) begin
				b = a; a = a + $urandom_range(1, 100);  // inverted or random
				if ($urandom_range(0, 1)) a = $urandom();
			end
			send_item(f, a, b);
		end

		start <= 1'b0;
		wait (pending == 0);
		repeat (20) @(negedge clk);
		$display("Covered %0d items: add, remove, check and next over sparse,", n_items);
		$display("full and split tables, with inverted and extreme spans.");
		if (fail_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("Regression FAIL");
		$finish;
	end
endmodule

### files.f
hdl/arbt_pkg.sv
hdl/arbt_cell.sv
hdl/address_range_ban_table.sv
tb/address_range_ban_table_chk.sv
tb/address_range_ban_table_tb.sv
